/* rtl/tsdc_pkg.sv */
// Package for the throttle speed and direction control unit.
// Holds the item, result, state and configuration types and the code constants.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tsdc_pkg;

	localparam logic [1:0] OP_UPDATE  = 2'd0;
	localparam logic [1:0] OP_ATTACH  = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;

	localparam logic [1:0] CONF_NONE  = 2'd0;
	localparam logic [1:0] CONF_CLICK = 2'd1;
	localparam logic [1:0] CONF_LONG  = 2'd2;
	localparam logic [1:0] CONF_BAD   = 2'd3;

	localparam logic [2:0] SEL_NONE       = 3'd0;
	localparam logic [2:0] SEL_UP_NORMAL  = 3'd1;
	localparam logic [2:0] SEL_UP_FASTER  = 3'd2;
	localparam logic [2:0] SEL_UP_FASTEST = 3'd3;
	localparam logic [2:0] SEL_DN_NORMAL  = 3'd4;
	localparam logic [2:0] SEL_DN_FASTER  = 3'd5;
	localparam logic [2:0] SEL_DN_FASTEST = 3'd6;
	localparam logic [2:0] SEL_BAD        = 3'd7;

	localparam logic [1:0] REG_STEP_NORMAL  = 2'd0;
	localparam logic [1:0] REG_STEP_FASTER  = 2'd1;
	localparam logic [1:0] REG_STEP_FASTEST = 2'd2;
	localparam logic [1:0] REG_SYNC_TIMEOUT = 2'd3;

	localparam logic signed [7:0] SPEED_MAX  = 8'sd126;
	localparam logic signed [7:0] SPEED_ESTOP = -8'sd1;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [1:0]  confirm_action;
		logic [2:0]  select_action;
		logic [6:0]  real_speed;
		logic        real_direction;
		logic [31:0] now_ms;
		logic [2:0]  ack_flags;
	} item_t;

	typedef struct packed {
		logic [6:0]  step_normal;
		logic [6:0]  step_faster;
		logic [6:0]  step_fastest;
		logic [31:0] sync_timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic signed [7:0] speed;
		logic              direction;
		logic              speed_chg;
		logic              dir_chg;
		logic              loco_chg;
		logic              present;
		logic [31:0]       last_ms;
	} state_t;

	typedef struct packed {
		logic              first_send;
		logic signed [7:0] first_speed;
		logic              second_send;
		logic signed [7:0] second_speed;
		logic              send_direction;
		logic signed [7:0] speed;
		logic              direction;
		logic              speed_flag;
		logic              direction_flag;
		logic              loco_flag;
		logic              attached;
	} result_t;

endpackage

/* rtl/tsdc_cfg_regs.sv */
// Configuration registers of the throttle control unit: step sizes and sync timeout.
// Depends on tsdc_pkg.
`timescale 1ns / 1ps

module tsdc_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_wdata,
	output tsdc_pkg::cfg_t cfg
);
	import tsdc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_normal     <= 7'd1;
			cfg_q.step_faster     <= 7'd2;
			cfg_q.step_fastest    <= 7'd5;
			cfg_q.sync_timeout_ms <= 32'd1000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STEP_NORMAL:  cfg_q.step_normal     <= cfg_wdata[6:0];
				REG_STEP_FASTER:  cfg_q.step_faster     <= cfg_wdata[6:0];
				REG_STEP_FASTEST: cfg_q.step_fastest    <= cfg_wdata[6:0];
				REG_SYNC_TIMEOUT: cfg_q.sync_timeout_ms <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/tsdc_update.sv */
// Next-state and result logic for one item: acknowledge, attach/release,
// button, step with clamp, idle resync. Depends on tsdc_pkg.
`timescale 1ns / 1ps

module tsdc_update (
	input  tsdc_pkg::item_t   item,
	input  tsdc_pkg::state_t  st,
	input  tsdc_pkg::cfg_t    cfg,
	output tsdc_pkg::state_t  st_next,
	output tsdc_pkg::result_t res
);
	import tsdc_pkg::*;

	logic [1:0]        conf;
	logic [2:0]        sel;
	logic [6:0]        step;
	logic              up;
	logic signed [8:0] ns;
	logic signed [7:0] ns8;
	logic signed [7:0] real_spd;
	logic [31:0]       idle_ms;
	state_t            s;
	logic              s1;
	logic              s2;
	logic signed [7:0] sp1;
	logic signed [7:0] sp2;

	always_comb begin
		conf = (item.confirm_action == CONF_BAD) ? CONF_NONE : item.confirm_action;
		sel  = (item.select_action == SEL_BAD) ? SEL_NONE : item.select_action;
		real_spd = signed'({1'b0, item.real_speed});

		case (sel)
			SEL_UP_NORMAL, SEL_DN_NORMAL:   step = cfg.step_normal;
			SEL_UP_FASTER, SEL_DN_FASTER:   step = cfg.step_faster;
			SEL_UP_FASTEST, SEL_DN_FASTEST: step = cfg.step_fastest;
			default:                        step = 7'd0;
		endcase
		up = (sel == SEL_UP_NORMAL) || (sel == SEL_UP_FASTER) || (sel == SEL_UP_FASTEST);

		s  = st;
		s1 = 1'b0;
		s2 = 1'b0;
		sp1 = 8'sd0;
		sp2 = 8'sd0;
		ns  = 9'sd0;
		ns8 = 8'sd0;
		idle_ms = 32'd0;

		if (item.ack_flags[0]) s.speed_chg = 1'b0;
		if (item.ack_flags[1]) s.dir_chg   = 1'b0;
		if (item.ack_flags[2]) s.loco_chg  = 1'b0;

		case (item.opcode)
			OP_ATTACH: begin
				s.present   = 1'b1;
				s.loco_chg  = 1'b1;
				s.speed     = real_spd;
				s.direction = item.real_direction;
				s.last_ms   = 32'd0;
			end
			OP_RELEASE: begin
				if (s.present && item.real_speed == 7'd0) begin
					s.present  = 1'b0;
					s.loco_chg = 1'b1;
				end
			end
			OP_UPDATE: begin
				if (conf != CONF_NONE || sel != SEL_NONE)
					s.last_ms = item.now_ms;

				if (s.present && conf != CONF_NONE) begin
					if (conf == CONF_CLICK) begin
						if (s.speed > 8'sd0) begin
							s.speed     = 8'sd0;
							s.speed_chg = 1'b1;
						end else begin
							s.direction = ~s.direction;
							s.dir_chg   = 1'b1;
						end
					end else begin
						s.speed     = SPEED_ESTOP;
						s.speed_chg = 1'b1;
					end
					s1  = 1'b1;
					sp1 = s.speed;
				end

				if (s.present && sel != SEL_NONE) begin
					if (up)
						ns = 9'(s.speed) + signed'({2'b00, step});
					else
						ns = 9'(s.speed) - signed'({2'b00, step});
					if (ns > 9'sd126)
						ns8 = SPEED_MAX;
					else if (ns < 9'sd0)
						ns8 = 8'sd0;
					else
						ns8 = ns[7:0];
					if (ns8 != s.speed) begin
						s.speed     = ns8;
						s.speed_chg = 1'b1;
						s2  = 1'b1;
						sp2 = ns8;
					end
				end

				idle_ms = item.now_ms - s.last_ms;
				if (s.present && idle_ms > cfg.sync_timeout_ms) begin
					if (s.direction != item.real_direction) begin
						s.direction = item.real_direction;
						s.dir_chg   = 1'b1;
					end
					if (sel == SEL_NONE && s.speed != real_spd) begin
						s.speed     = real_spd;
						s.speed_chg = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	assign st_next = s;

	always_comb begin
		res.first_send     = s1;
		res.first_speed    = sp1;
		res.second_send    = s2;
		res.second_speed   = sp2;
		res.send_direction = (s1 || s2) ? s.direction : 1'b0;
		res.speed          = s.speed;
		res.direction      = s.direction;
		res.speed_flag     = s.speed_chg;
		res.direction_flag = s.dir_chg;
		res.loco_flag      = s.loco_chg;
		res.attached       = s.present;
	end

endmodule

/* rtl/throttle_speed_direction_control_unit.sv */
// Usage
// Top level of the throttle speed and direction control unit.
// Depends on tsdc_pkg, tsdc_cfg_regs and tsdc_update.
//
// Input channel (in_valid/in_ready) carries one item: attach, release or
// update, with button, step selection, real loco values, time and flag ack.
// Output channel (out_valid/out_ready) returns exactly one result per item:
// commands issued and the throttle state and sticky flags after the item.
// An item is captured in the input register, then the update logic
// writes the throttle state and the result register at the same edge:
// out_valid is registered alongside the result, and one item is taken
// every cycle as long as results are taken. The single update pass sets the
// rate: each item reads the state the previous item left.
// When the receiver stalls, the result register holds, the item in the input
// register waits, and in_ready falls once both are full.
// Reset clears the state (speed 0, forward, no loco, flags clear), the
// configuration to its defaults, and both valid bits.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once;
// issue them only while no item is in flight.
`timescale 1ns / 1ps

module throttle_speed_direction_control_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        opcode,
	input  logic [1:0]        confirm_action,
	input  logic [2:0]        select_action,
	input  logic [6:0]        real_speed,
	input  logic              real_direction,
	input  logic [31:0]       now_ms,
	input  logic [2:0]        ack_flags,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              first_send,
	output logic signed [7:0] first_speed,
	output logic              second_send,
	output logic signed [7:0] second_speed,
	output logic              send_direction,
	output logic signed [7:0] speed,
	output logic              direction,
	output logic              speed_flag,
	output logic              direction_flag,
	output logic              loco_flag,
	output logic              attached
);
	import tsdc_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	state_t  st_q;
	state_t  st_next;
	result_t res_next;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;

	tsdc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tsdc_update u_update (
		.item    (item_s1),
		.st      (st_q),
		.cfg     (cfg),
		.st_next (st_next),
		.res     (res_next)
	);

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.opcode         <= opcode;
			item_s1.confirm_action <= confirm_action;
			item_s1.select_action  <= select_action;
			item_s1.real_speed     <= real_speed;
			item_s1.real_direction <= real_direction;
			item_s1.now_ms         <= now_ms;
			item_s1.ack_flags      <= ack_flags;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.speed     <= 8'sd0;
			st_q.direction <= 1'b0;
			st_q.speed_chg <= 1'b0;
			st_q.dir_chg   <= 1'b0;
			st_q.loco_chg  <= 1'b0;
			st_q.present   <= 1'b0;
			st_q.last_ms   <= 32'd0;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign out_valid      = out_valid_q;
	assign first_send     = res_q.first_send;
	assign first_speed    = res_q.first_speed;
	assign second_send    = res_q.second_send;
	assign second_speed   = res_q.second_speed;
	assign send_direction = res_q.send_direction;
	assign speed          = res_q.speed;
	assign direction      = res_q.direction;
	assign speed_flag     = res_q.speed_flag;
	assign direction_flag = res_q.direction_flag;
	assign loco_flag      = res_q.loco_flag;
	assign attached       = res_q.attached;

	a_state_matches_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (res_q.attached == st_q.present) && (res_q.speed == st_q.speed)
			&& (res_q.direction == st_q.direction))
		else $error("result register does not match throttle state");

	a_send_needs_loco: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.first_send || res_q.second_send) |-> res_q.attached)
		else $error("command issued without an attached loco");

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.second_send |->
			(res_q.second_speed >= 8'sd0) && (res_q.second_speed <= SPEED_MAX))
		else $error("step command speed out of range");

	a_idle_send_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.first_send && !res_q.second_send |->
			(res_q.first_speed == 8'sd0) && (res_q.second_speed == 8'sd0)
			&& !res_q.send_direction)
		else $error("command fields set without a command");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> $stable(st_q))
		else $error("state advanced while result stalled");

endmodule
